[rtl/srl_pkg.sv]
// ----------------------------------------------------------------------------
// srl_pkg
// types and constants shared by the symbol range lookup block
// ----------------------------------------------------------------------------
package srl_pkg;

  localparam int TABLE_DEPTH_DEF = 256;
  localparam int IDX_W           = 8;
  localparam int ADDR_W          = 32;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 32;
  localparam int COUNT_W         = 9;

  localparam logic [3:0] FUNC_TYPE = 4'd2;

  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_TABLES_PRESENT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STRING_TABLE_BASE = 2'd2;

  typedef struct packed {
    logic              action;
    logic [IDX_W-1:0]  entry_index;
    logic [ADDR_W-1:0] entry_start;
    logic [ADDR_W-1:0] entry_length;
    logic [7:0]        entry_info;
    logic [ADDR_W-1:0] entry_name_offset;
    logic [ADDR_W-1:0] lookup_address;
  } in_t;

  typedef struct packed {
    logic              found;
    logic [IDX_W-1:0]  match_index;
    logic [ADDR_W-1:0] name_address;
  } out_t;

  // entry write broadcast to the row of cells
  typedef struct packed {
    logic              valid;
    logic [IDX_W-1:0]  index;
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] stop;
    logic              is_func;
    logic [ADDR_W-1:0] name_offset;
  } ld_t;

  // search token moving down the row
  typedef struct packed {
    logic              valid;
    logic              found;
    logic [IDX_W-1:0]  match_index;
    logic [ADDR_W-1:0] name_offset;
    logic [ADDR_W-1:0] address;
  } tok_t;

endpackage

[rtl/srl_cell.sv]
// ----------------------------------------------------------------------------
// srl_cell
// one symbol table slot: holds its entry and checks the passing search token
// ----------------------------------------------------------------------------
module srl_cell #(
  parameter int CELL_IDX = 0,
  parameter int CNT_W    = 9
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  srl_pkg::ld_t   ld,
  input  logic [CNT_W-1:0] limit,
  input  srl_pkg::tok_t  tok_i,
  output srl_pkg::tok_t  tok_o
);
  import srl_pkg::*;

  logic [ADDR_W-1:0] start_r;
  logic [ADDR_W-1:0] stop_r;
  logic              is_func_r;
  logic [ADDR_W-1:0] name_off_r;
  tok_t              tok_r;
  tok_t              tok_nxt;
  logic              hit;

  // entry storage, written by a load transaction aimed at this slot
  always_ff @(posedge clk) begin
    if (ld.valid && (int'(ld.index) == CELL_IDX)) begin
      start_r    <= ld.start;
      stop_r     <= ld.stop;
      is_func_r  <= ld.is_func;
      name_off_r <= ld.name_offset;
    end
  end

  always_comb begin
    hit = tok_i.valid && !tok_i.found && (CELL_IDX < int'(limit)) && is_func_r &&
          (tok_i.address > start_r) && (tok_i.address <= stop_r);
    tok_nxt = tok_i;
    if (hit) begin
      tok_nxt.found       = 1'b1;
      tok_nxt.match_index = IDX_W'(CELL_IDX);
      tok_nxt.name_offset = name_off_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else if (adv) begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_o = tok_r;

endmodule

[rtl/symbol_range_lookup.sv]
// ----------------------------------------------------------------------------
// symbol_range_lookup
// finds the first function symbol whose range holds an address
// ----------------------------------------------------------------------------
// usage
//   in_*  : valid/ready channel of in_t transactions; action load writes one
//           table slot (start, length, info, name offset), action lookup
//           searches for lookup_address
//   out_* : valid/ready channel of out_t transactions, one per lookup only
//   cfg_* : register writes (tables_present, entry_count, string_table_base),
//           taken at any edge with cfg_we high; write only while idle (not enforced)
//   a load is written into its slot as it is accepted; loads are accepted back to back when no lookup runs
//   a lookup token walks the row of TABLE_DEPTH cells, one cell per cycle
//   while the row is not frozen; in_ready returns in the same cycle as the
//   result becomes valid, so a new transaction is accepted only after the
//   previous lookup has left the row
//   reset clears the config registers, busy, out_valid and the token valid
//   bits; table contents are undefined until loaded
//   a stalled receiver holds the result in the output register; a finished
//   token then freezes the whole row until the result is taken
// ----------------------------------------------------------------------------
module symbol_range_lookup #(
  parameter int TABLE_DEPTH = srl_pkg::TABLE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  srl_pkg::in_t                     in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output srl_pkg::out_t                    out_data,
  input  logic                             cfg_we,
  input  logic [srl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [srl_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import srl_pkg::*;

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  logic               tables_present_r;
  logic [COUNT_W-1:0] entry_count_r;
  logic [ADDR_W-1:0]  str_base_r;
  logic               busy_r;
  logic               out_valid_r;
  out_t               out_r;
  logic [CNT_W-1:0]   limit;
  logic               adv;
  logic               take_in;
  logic               lookup_acc;
  logic               done;
  ld_t                ld;
  tok_t               tok [TABLE_DEPTH+1];

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tables_present_r <= 1'b0;
      entry_count_r    <= '0;
      str_base_r       <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TABLES_PRESENT:    tables_present_r <= cfg_wdata[0];
        CFG_ENTRY_COUNT:       entry_count_r    <= cfg_wdata[COUNT_W-1:0];
        CFG_STRING_TABLE_BASE: str_base_r       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (!tables_present_r) begin
      limit = '0;
    end else if (int'(entry_count_r) > TABLE_DEPTH) begin
      limit = CNT_W'(TABLE_DEPTH);
    end else begin
      limit = CNT_W'(entry_count_r);
    end
  end

  assign in_ready   = !busy_r;
  assign take_in    = in_valid && in_ready;
  assign lookup_acc = take_in && (in_data.action == ACT_LOOKUP);
  assign adv        = !(tok[TABLE_DEPTH].valid && out_valid_r && !out_ready);
  assign done       = adv && tok[TABLE_DEPTH].valid;

  always_comb begin
    ld.valid       = take_in && (in_data.action == ACT_LOAD);
    ld.index       = in_data.entry_index;
    ld.start       = in_data.entry_start;
    ld.stop        = in_data.entry_start + in_data.entry_length;
    ld.is_func     = (in_data.entry_info[3:0] == FUNC_TYPE);
    ld.name_offset = in_data.entry_name_offset;
  end

  always_comb begin
    tok[0].valid       = lookup_acc;
    tok[0].found       = 1'b0;
    tok[0].match_index = '0;
    tok[0].name_offset = '0;
    tok[0].address     = in_data.lookup_address;
  end

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    srl_cell #(
      .CELL_IDX (g),
      .CNT_W    (CNT_W)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .ld    (ld),
      .limit (limit),
      .tok_i (tok[g]),
      .tok_o (tok[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (lookup_acc) begin
      busy_r <= 1'b1;
    end else if (done) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_r.found       <= tok[TABLE_DEPTH].found;
      out_r.match_index <= tok[TABLE_DEPTH].found ? tok[TABLE_DEPTH].match_index : '0;
      out_r.name_address <= tok[TABLE_DEPTH].found ?
                            (str_base_r + tok[TABLE_DEPTH].name_offset) : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef ASSERT_OFF
  a_idle_row_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> !tok[TABLE_DEPTH].valid)
    else $error("token at end of row while idle");

  a_lookup_busy: assert property (@(posedge clk) disable iff (!rst_n)
    lookup_acc |=> busy_r)
    else $error("lookup accepted without going busy");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.found) |-> (out_r.name_address == '0 && out_r.match_index == '0))
    else $error("miss result carries nonzero fields");

  a_absent_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (!tables_present_r && tok[TABLE_DEPTH].valid) |-> !tok[TABLE_DEPTH].found)
    else $error("hit while tables absent");
`endif

endmodule
